>>> sv/fly_camera_orientation_update_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the fly camera orientation updater
// Clocked on clk_i and disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef FLY_CAMERA_ORIENTATION_UPDATE_ASSERT_SVH
`define FLY_CAMERA_ORIENTATION_UPDATE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define FCOU_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define FCOU_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> sv/fcou_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fcou_pkg
// Shared types and constants of the fly camera orientation updater.
// ----------------------------------------------------------------------------
package fcou_pkg;

  // Item operation codes.
  localparam logic OP_TRANSLATE = 1'b0;
  localparam logic OP_ROTATE    = 1'b1;

  // Configuration register indexes.
  localparam logic CFG_MOVE_SPEED = 1'b0;
  localparam logic CFG_TURN_SENS  = 1'b1;

  // Configuration widths and reset values.
  localparam int unsigned SPEED_W = 24;
  localparam int unsigned SENS_W  = 16;
  localparam logic [SPEED_W-1:0] SPEED_RESET = 24'd131072;
  localparam logic [SENS_W-1:0]  SENS_RESET  = 16'd4660;

  // Angle constants: a full turn is 65536 units.
  localparam logic [15:0]        ANGLE_QUARTER = 16'd16384;
  localparam logic [15:0]        YAW_RESET     = 16'd49152;
  localparam logic signed [14:0] PITCH_LIMIT   = 15'sd16201;

  // Unit length of the front vector in Q1.14.
  localparam logic signed [15:0] ONE_Q14 = 16'sd16384;

  // Depth of the command queue between the front and the back end.
  localparam int unsigned CMD_FIFO_DEPTH = 2;

  // One classified command as it travels from the front to the back end.
  typedef struct packed {
    logic               op;
    logic               move_forward;
    logic               move_back;
    logic               move_left;
    logic               move_right;
    logic [15:0]        yaw;
    logic signed [14:0] pitch;
  } cmd_t;

endpackage

>>> sv/fcou_cmd_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fcou_cmd_fifo
// Short command queue that decouples the front end from the back end.
// ----------------------------------------------------------------------------
module fcou_cmd_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  fcou_pkg::cmd_t data_i,
  output logic          full_o,
  input  logic          pop_i,
  output fcou_pkg::cmd_t data_o,
  output logic          empty_o
);

  localparam int unsigned PTR_W = (fcou_pkg::CMD_FIFO_DEPTH > 1) ?
                                  $clog2(fcou_pkg::CMD_FIFO_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(fcou_pkg::CMD_FIFO_DEPTH + 1);

  fcou_pkg::cmd_t entry_q [fcou_pkg::CMD_FIFO_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             do_push, do_pop;

  assign full_o  = (count_q == CNT_W'(fcou_pkg::CMD_FIFO_DEPTH));
  assign empty_o = (count_q == '0);
  assign data_o  = entry_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(fcou_pkg::CMD_FIFO_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(fcou_pkg::CMD_FIFO_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Entry storage needs no reset.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

>>> sv/fcou_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fcou_front
// Front end: takes items, scales the mouse offsets, updates yaw and pitch
// and hands a classified command to the back end.
// ----------------------------------------------------------------------------
module fcou_front (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic [fcou_pkg::SENS_W-1:0]       turn_sens_i,
  input  logic                              push_i,
  output logic                              full_o,
  input  logic                              operation_i,
  input  logic                              move_forward_i,
  input  logic                              move_back_i,
  input  logic                              move_left_i,
  input  logic                              move_right_i,
  input  logic signed [15:0]                x_offset_i,
  input  logic signed [15:0]                y_offset_i,
  output logic                              cmd_push_o,
  input  logic                              cmd_full_i,
  output fcou_pkg::cmd_t                    cmd_o
);

  localparam logic [1:0] F_IDLE = 2'd0;
  localparam logic [1:0] F_MUL  = 2'd1;
  localparam logic [1:0] F_PUSH = 2'd2;

  logic [1:0]         state_q, state_d;
  logic               op_q, fwd_q, bwd_q, left_q, right_q;
  logic signed [15:0] xoff_q, yoff_q;
  logic signed [32:0] yaw_prod_q, yaw_prod_d;
  logic signed [32:0] pitch_prod_q, pitch_prod_d;
  logic [15:0]        yaw_q, yaw_d;
  logic signed [14:0] pitch_q, pitch_d;
  logic signed [32:0] yaw_delta, pitch_delta;
  logic [15:0]        yaw_new;
  logic signed [25:0] pitch_sum;
  logic signed [14:0] pitch_new;
  logic               accept;

  assign full_o = (state_q != F_IDLE);
  assign accept = push_i && !full_o;

  // Scaled offsets, rounded to nearest with ties upward.
  assign yaw_delta   = (yaw_prod_q + 33'sd128) >>> 8;
  assign pitch_delta = (pitch_prod_q + 33'sd128) >>> 8;
  assign yaw_new     = yaw_q + yaw_delta[15:0];
  assign pitch_sum   = 26'(pitch_q) + 26'(pitch_delta);

  // Pitch clamp to the limit in both directions.
  always_comb begin
    if (pitch_sum > 26'(fcou_pkg::PITCH_LIMIT)) begin
      pitch_new = fcou_pkg::PITCH_LIMIT;
    end else if (pitch_sum < -26'(fcou_pkg::PITCH_LIMIT)) begin
      pitch_new = -fcou_pkg::PITCH_LIMIT;
    end else begin
      pitch_new = pitch_sum[14:0];
    end
  end

  // Command toward the back end carries the angles after this item.
  always_comb begin
    cmd_o.op           = op_q;
    cmd_o.move_forward = fwd_q;
    cmd_o.move_back    = bwd_q;
    cmd_o.move_left    = left_q;
    cmd_o.move_right   = right_q;
    if (op_q == fcou_pkg::OP_ROTATE) begin
      cmd_o.yaw   = yaw_new;
      cmd_o.pitch = pitch_new;
    end else begin
      cmd_o.yaw   = yaw_q;
      cmd_o.pitch = pitch_q;
    end
  end

  assign cmd_push_o = (state_q == F_PUSH) && !cmd_full_i;

  // Sequencer and angle state.
  always_comb begin
    state_d      = state_q;
    yaw_d        = yaw_q;
    pitch_d      = pitch_q;
    yaw_prod_d   = yaw_prod_q;
    pitch_prod_d = pitch_prod_q;
    unique case (state_q)
      F_IDLE: begin
        if (accept) begin
          state_d = F_MUL;
        end
      end
      F_MUL: begin
        yaw_prod_d   = 33'(xoff_q) * 33'($signed({1'b0, turn_sens_i}));
        pitch_prod_d = 33'(yoff_q) * 33'($signed({1'b0, turn_sens_i}));
        state_d      = F_PUSH;
      end
      F_PUSH: begin
        if (!cmd_full_i) begin
          if (op_q == fcou_pkg::OP_ROTATE) begin
            yaw_d   = yaw_new;
            pitch_d = pitch_new;
          end
          state_d = F_IDLE;
        end
      end
      default: begin
        state_d = F_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
      yaw_q   <= fcou_pkg::YAW_RESET;
      pitch_q <= '0;
    end else begin
      state_q <= state_d;
      yaw_q   <= yaw_d;
      pitch_q <= pitch_d;
    end
  end

  // Item fields and products carry no reset.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q    <= operation_i;
      fwd_q   <= move_forward_i;
      bwd_q   <= move_back_i;
      left_q  <= move_left_i;
      right_q <= move_right_i;
      xoff_q  <= x_offset_i;
      yoff_q  <= y_offset_i;
    end
    yaw_prod_q   <= yaw_prod_d;
    pitch_prod_q <= pitch_prod_d;
  end

endmodule

>>> sv/fcou_sine_rom.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fcou_sine_rom
// Quarter-wave sine table with a registered read. Maps a 16-bit angle to
// its Q1.14 sine, mirroring and negating per quadrant.
// ----------------------------------------------------------------------------
module fcou_sine_rom #(
  parameter int unsigned SINE_TABLE_DEPTH = 1024
) (
  input  logic              clk_i,
  input  logic [15:0]       angle_i,
  output logic signed [15:0] sine_o
);

  localparam int unsigned IDX_W  = $clog2(SINE_TABLE_DEPTH + 1);
  localparam int unsigned PROD_W = IDX_W + 15;
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
  localparam logic [63:0] SERIES_DIV [12] = '{
    64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156,
    64'd210, 64'd272, 64'd342, 64'd420, 64'd506, 64'd600
  };

  // Table entry from the integer Taylor series in Q30, evaluated at elaboration.
  function automatic logic [14:0] quarter_sine(input int unsigned idx);
    logic [63:0]        x;
    logic [63:0]        x2;
    logic [63:0]        term;
    logic signed [63:0] acc;
    logic signed [63:0] r;
    x    = (HALF_PI_Q30 * 64'(idx)) / SINE_TABLE_DEPTH;
    x2   = (x * x) >> 30;
    term = x;
    acc  = $signed(x);
    for (int k = 1; k <= 12; k++) begin
      term = ((term * x2) >> 30) / SERIES_DIV[k-1];
      if (k[0]) begin
        acc = acc - $signed(term);
      end else begin
        acc = acc + $signed(term);
      end
    end
    if (acc < 0) begin
      acc = 0;
    end
    r = (acc + 64'sd32768) >>> 16;
    if (r > 64'sd16384) begin
      r = 64'sd16384;
    end
    return r[14:0];
  endfunction

  logic [14:0]        sine_tbl [SINE_TABLE_DEPTH+1];
  logic [PROD_W-1:0]  scaled;
  logic [PROD_W-15:0] idx_raw;
  logic [IDX_W-1:0]   idx_clamped;
  logic [IDX_W-1:0]   idx;
  logic [14:0]        mag_q;
  logic               neg_q;

  for (genvar g = 0; g <= SINE_TABLE_DEPTH; g++) begin : g_tbl
    assign sine_tbl[g] = quarter_sine(g);
  end

  // Index within the quadrant, rounded to nearest, mirrored in odd quadrants.
  assign scaled  = PROD_W'(angle_i[13:0]) * PROD_W'(SINE_TABLE_DEPTH) + PROD_W'(8192);
  assign idx_raw = scaled[PROD_W-1:14];

  always_comb begin
    if (idx_raw > (PROD_W-14)'(SINE_TABLE_DEPTH)) begin
      idx_clamped = IDX_W'(SINE_TABLE_DEPTH);
    end else begin
      idx_clamped = idx_raw[IDX_W-1:0];
    end
    if (angle_i[14]) begin
      idx = IDX_W'(SINE_TABLE_DEPTH) - idx_clamped;
    end else begin
      idx = idx_clamped;
    end
  end

  // Registered table read; the sign follows the upper half turn.
  always_ff @(posedge clk_i) begin
    mag_q <= sine_tbl[idx];
    neg_q <= angle_i[15];
  end

  assign sine_o = neg_q ? -$signed({1'b0, mag_q}) : $signed({1'b0, mag_q});

endmodule

>>> sv/fcou_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fcou_back
// Back end: looks up the sines for a command, rebuilds the front vector or
// moves the position with one shared multiplier, and holds the result slot.
// ----------------------------------------------------------------------------
module fcou_back #(
  parameter int unsigned SINE_TABLE_DEPTH       = 1024,
  parameter int unsigned POSITION_FRACTION_BITS = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic [fcou_pkg::SPEED_W-1:0] move_speed_i,
  input  logic                         cmd_empty_i,
  input  fcou_pkg::cmd_t               cmd_i,
  output logic                         cmd_pop_o,
  output logic                         empty_o,
  input  logic                         pop_i,
  output logic signed [31:0]           position_x_o,
  output logic signed [31:0]           position_y_o,
  output logic signed [31:0]           position_z_o,
  output logic signed [15:0]           front_x_o,
  output logic signed [15:0]           front_y_o,
  output logic signed [15:0]           front_z_o,
  output logic [15:0]                  yaw_angle_o,
  output logic signed [14:0]           pitch_angle_o
);

  localparam int unsigned        SHIFT     = 30 - POSITION_FRACTION_BITS;
  localparam logic signed [43:0] ROUND_ADD = 44'sd1 <<< (SHIFT - 1);
  localparam logic signed [43:0] POS_MAX   = 44'sd2147483647;
  localparam logic signed [43:0] POS_MIN   = -44'sd2147483648;
  localparam logic signed [31:0] POS_Z_RESET = 32'(64'sd3 <<< POSITION_FRACTION_BITS);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_LOOK = 3'd1;
  localparam logic [2:0] S_MUL  = 3'd2;
  localparam logic [2:0] S_ACC  = 3'd3;
  localparam logic [2:0] S_DONE = 3'd4;

  logic [2:0]         state_q, state_d;
  logic [2:0]         step_q, step_d;
  logic [1:0]         axis_q, axis_d;
  fcou_pkg::cmd_t     cmd_q, cmd_d;
  logic signed [15:0] sy_q, sy_d, cy_q, cy_d, sp_q, sp_d, cp_q, cp_d;
  logic signed [42:0] prod_q, prod_d;
  logic signed [31:0] pos_x_q, pos_x_d, pos_y_q, pos_y_d, pos_z_q, pos_z_d;
  logic signed [15:0] dir_x_q, dir_x_d, dir_y_q, dir_y_d, dir_z_q, dir_z_d;
  logic               out_valid_q, out_valid_d;
  logic               load_out;
  logic               rotate;
  logic [15:0]        pitch_ext;
  logic [15:0]        rom_angle;
  logic signed [15:0] rom_rd;
  logic signed [17:0] mul_a;
  logic signed [24:0] mul_b;
  logic signed [42:0] dir_rnd;
  logic signed [43:0] pos_delta;
  logic signed [31:0] pos_sel;
  logic signed [43:0] pos_sum;
  logic signed [31:0] pos_sat;
  logic               last_axis;

  // Signed pick of a value by two opposing flags; both or neither give zero.
  function automatic logic signed [17:0] flag_term(input logic plus, input logic minus,
                                                   input logic signed [15:0] v);
    logic signed [17:0] ext;
    ext = 18'(v);
    if (plus && !minus) begin
      return ext;
    end else if (minus && !plus) begin
      return -ext;
    end else begin
      return '0;
    end
  endfunction

  assign rotate    = (cmd_q.op == fcou_pkg::OP_ROTATE);
  assign pitch_ext = {cmd_q.pitch[14], cmd_q.pitch};
  assign last_axis = rotate ? (axis_q == 2'd1) : (axis_q == 2'd2);

  // Sine table lookups in order: sin yaw, cos yaw, sin pitch, cos pitch.
  always_comb begin
    case (step_q)
      3'd0:    rom_angle = cmd_q.yaw;
      3'd1:    rom_angle = cmd_q.yaw + fcou_pkg::ANGLE_QUARTER;
      3'd2:    rom_angle = pitch_ext;
      default: rom_angle = pitch_ext + fcou_pkg::ANGLE_QUARTER;
    endcase
  end

  fcou_sine_rom #(
    .SINE_TABLE_DEPTH(SINE_TABLE_DEPTH)
  ) u_sine_rom (
    .clk_i  (clk_i),
    .angle_i(rom_angle),
    .sine_o (rom_rd)
  );

  // Operands of the shared multiplier.
  always_comb begin
    if (rotate) begin
      mul_a = (axis_q == 2'd0) ? 18'(cy_q) : 18'(sy_q);
      mul_b = 25'(cp_q);
    end else begin
      mul_b = $signed({1'b0, move_speed_i});
      case (axis_q)
        2'd0:    mul_a = flag_term(cmd_q.move_forward, cmd_q.move_back, dir_x_q)
                         - flag_term(cmd_q.move_right, cmd_q.move_left, sy_q);
        2'd1:    mul_a = flag_term(cmd_q.move_forward, cmd_q.move_back, dir_y_q);
        default: mul_a = flag_term(cmd_q.move_forward, cmd_q.move_back, dir_z_q)
                         + flag_term(cmd_q.move_right, cmd_q.move_left, cy_q);
      endcase
    end
  end

  // Rounding of the Q28 front product back to Q1.14.
  assign dir_rnd = (prod_q + 43'sd8192) >>> 14;

  // Rounded position step and saturating add on the selected axis.
  assign pos_delta = (44'(prod_q) + ROUND_ADD) >>> SHIFT;

  always_comb begin
    case (axis_q)
      2'd0:    pos_sel = pos_x_q;
      2'd1:    pos_sel = pos_y_q;
      default: pos_sel = pos_z_q;
    endcase
  end

  assign pos_sum = 44'(pos_sel) + pos_delta;

  always_comb begin
    if (pos_sum > POS_MAX) begin
      pos_sat = POS_MAX[31:0];
    end else if (pos_sum < POS_MIN) begin
      pos_sat = POS_MIN[31:0];
    end else begin
      pos_sat = pos_sum[31:0];
    end
  end

  assign cmd_pop_o = (state_q == S_IDLE) && !cmd_empty_i;
  assign load_out  = (state_q == S_DONE) && (!out_valid_q || pop_i);

  // Back end sequencer.
  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    axis_d  = axis_q;
    cmd_d   = cmd_q;
    sy_d    = sy_q;
    cy_d    = cy_q;
    sp_d    = sp_q;
    cp_d    = cp_q;
    prod_d  = prod_q;
    pos_x_d = pos_x_q;
    pos_y_d = pos_y_q;
    pos_z_d = pos_z_q;
    dir_x_d = dir_x_q;
    dir_y_d = dir_y_q;
    dir_z_d = dir_z_q;
    unique case (state_q)
      S_IDLE: begin
        if (!cmd_empty_i) begin
          cmd_d   = cmd_i;
          step_d  = '0;
          state_d = S_LOOK;
        end
      end
      S_LOOK: begin
        case (step_q)
          3'd1:    sy_d = rom_rd;
          3'd2:    cy_d = rom_rd;
          3'd3:    sp_d = rom_rd;
          3'd4:    cp_d = rom_rd;
          default: ;
        endcase
        if ((rotate && step_q == 3'd4) || (!rotate && step_q == 3'd2)) begin
          axis_d  = '0;
          state_d = S_MUL;
        end else begin
          step_d = step_q + 1'b1;
        end
      end
      S_MUL: begin
        prod_d  = 43'(mul_a) * 43'(mul_b);
        state_d = S_ACC;
      end
      S_ACC: begin
        if (rotate) begin
          if (axis_q == 2'd0) begin
            dir_x_d = dir_rnd[15:0];
          end else begin
            dir_z_d = dir_rnd[15:0];
            dir_y_d = sp_q;
          end
        end else begin
          case (axis_q)
            2'd0:    pos_x_d = pos_sat;
            2'd1:    pos_y_d = pos_sat;
            default: pos_z_d = pos_sat;
          endcase
        end
        if (last_axis) begin
          state_d = S_DONE;
        end else begin
          axis_d  = axis_q + 1'b1;
          state_d = S_MUL;
        end
      end
      S_DONE: begin
        if (load_out) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Result slot: a transfer frees it, a finished command fills it.
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && pop_i) begin
      out_valid_d = 1'b0;
    end
    if (load_out) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      step_q      <= '0;
      axis_q      <= '0;
      out_valid_q <= 1'b0;
      pos_x_q     <= '0;
      pos_y_q     <= '0;
      pos_z_q     <= POS_Z_RESET;
      dir_x_q     <= '0;
      dir_y_q     <= '0;
      dir_z_q     <= -fcou_pkg::ONE_Q14;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      axis_q      <= axis_d;
      out_valid_q <= out_valid_d;
      pos_x_q     <= pos_x_d;
      pos_y_q     <= pos_y_d;
      pos_z_q     <= pos_z_d;
      dir_x_q     <= dir_x_d;
      dir_y_q     <= dir_y_d;
      dir_z_q     <= dir_z_d;
    end
  end

  // Working registers and result payload carry no reset.
  always_ff @(posedge clk_i) begin
    cmd_q  <= cmd_d;
    sy_q   <= sy_d;
    cy_q   <= cy_d;
    sp_q   <= sp_d;
    cp_q   <= cp_d;
    prod_q <= prod_d;
    if (load_out) begin
      position_x_o  <= pos_x_q;
      position_y_o  <= pos_y_q;
      position_z_o  <= pos_z_q;
      front_x_o     <= dir_x_q;
      front_y_o     <= dir_y_q;
      front_z_o     <= dir_z_q;
      yaw_angle_o   <= cmd_q.yaw;
      pitch_angle_o <= cmd_q.pitch;
    end
  end

  assign empty_o = !out_valid_q;

endmodule

>>> sv/fly_camera_orientation_update.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fly_camera_orientation_update
// First-person fly camera: yaw/pitch update and position translation.
// ----------------------------------------------------------------------------
// Each accepted item yields one result with the whole camera state after it.
// A front end accepts an item, scales the mouse offsets and updates yaw and
// pitch, then hands a command to a two-entry queue. The back end pops it and
// works through it: a pop, two (translate) or four (rotate) reads of the
// single-port sine table plus the registered read, two or three passes
// through the one shared multiplier, each a multiply state and an accumulate
// state, and a final load of the result register. The back end sequencer
// takes a new command only once it has loaded the last result, and so sets
// the sustained rate. The sine table holds SINE_TABLE_DEPTH + 1 constant
// entries and needs no fill after reset.
// Configuration writes take effect at once and are meant for an idle block.
// ----------------------------------------------------------------------------
module fly_camera_orientation_update #(
  parameter int unsigned SINE_TABLE_DEPTH       = 1024,
  parameter int unsigned POSITION_FRACTION_BITS = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // Configuration write port.
  input  logic                         cfg_we_i,
  input  logic                         cfg_index_i,
  input  logic [fcou_pkg::SPEED_W-1:0] cfg_data_i,
  // Item input.
  input  logic                         push,
  output logic                         full,
  input  logic                         operation_i,
  input  logic                         move_forward_i,
  input  logic                         move_back_i,
  input  logic                         move_left_i,
  input  logic                         move_right_i,
  input  logic signed [15:0]           x_offset_i,
  input  logic signed [15:0]           y_offset_i,
  // Result output.
  output logic                         empty,
  input  logic                         pop,
  output logic signed [31:0]           position_x_o,
  output logic signed [31:0]           position_y_o,
  output logic signed [31:0]           position_z_o,
  output logic signed [15:0]           front_x_o,
  output logic signed [15:0]           front_y_o,
  output logic signed [15:0]           front_z_o,
  output logic [15:0]                  yaw_angle_o,
  output logic signed [14:0]           pitch_angle_o
);

`include "fly_camera_orientation_update_assert.svh"

  logic [fcou_pkg::SPEED_W-1:0] move_speed_q;
  logic [fcou_pkg::SENS_W-1:0]  turn_sens_q;
  logic                         cmd_push, cmd_full, cmd_pop, cmd_empty;
  fcou_pkg::cmd_t               cmd_in, cmd_out;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      move_speed_q <= fcou_pkg::SPEED_RESET;
      turn_sens_q  <= fcou_pkg::SENS_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        fcou_pkg::CFG_MOVE_SPEED: move_speed_q <= cfg_data_i;
        fcou_pkg::CFG_TURN_SENS:  turn_sens_q  <= cfg_data_i[fcou_pkg::SENS_W-1:0];
        default: ;
      endcase
    end
  end

  // Front end: accepts items and updates the angles.
  fcou_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .turn_sens_i   (turn_sens_q),
    .push_i        (push),
    .full_o        (full),
    .operation_i   (operation_i),
    .move_forward_i(move_forward_i),
    .move_back_i   (move_back_i),
    .move_left_i   (move_left_i),
    .move_right_i  (move_right_i),
    .x_offset_i    (x_offset_i),
    .y_offset_i    (y_offset_i),
    .cmd_push_o    (cmd_push),
    .cmd_full_i    (cmd_full),
    .cmd_o         (cmd_in)
  );

  // Command queue between the two ends.
  fcou_cmd_fifo u_cmd_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (cmd_push),
    .data_i (cmd_in),
    .full_o (cmd_full),
    .pop_i  (cmd_pop),
    .data_o (cmd_out),
    .empty_o(cmd_empty)
  );

  // Back end: trigonometry, translation and the result register.
  fcou_back #(
    .SINE_TABLE_DEPTH      (SINE_TABLE_DEPTH),
    .POSITION_FRACTION_BITS(POSITION_FRACTION_BITS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .move_speed_i (move_speed_q),
    .cmd_empty_i  (cmd_empty),
    .cmd_i        (cmd_out),
    .cmd_pop_o    (cmd_pop),
    .empty_o      (empty),
    .pop_i        (pop),
    .position_x_o (position_x_o),
    .position_y_o (position_y_o),
    .position_z_o (position_z_o),
    .front_x_o    (front_x_o),
    .front_y_o    (front_y_o),
    .front_z_o    (front_z_o),
    .yaw_angle_o  (yaw_angle_o),
    .pitch_angle_o(pitch_angle_o)
  );

  // An input transfer keeps the front end busy for the next cycle.
  `FCOU_ASSERT_NEXT(a_push_busy, push && !full, full, "front end took an item while busy")
  // The command queue is never both full and empty.
  `FCOU_ASSERT_IMP(a_queue_flags, cmd_full, !cmd_empty, "command queue flags disagree")
  // A presented result keeps pitch within its clamp.
  `FCOU_ASSERT_IMP(a_pitch_range, !empty, (pitch_angle_o <= fcou_pkg::PITCH_LIMIT) && (pitch_angle_o >= -fcou_pkg::PITCH_LIMIT), "pitch outside its limit")
  // A presented result keeps the vertical front component within unit length.
  `FCOU_ASSERT_IMP(a_front_y_unit, !empty, (front_y_o <= fcou_pkg::ONE_Q14) && (front_y_o >= -fcou_pkg::ONE_Q14), "front vector exceeds unit length")

endmodule

>>> dv/fcou_camera_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fcou_camera_checker
// Watches the configuration, item and result channels of the fly camera
// updater. It keeps its own copy of the camera state and register values,
// works out the camera state after every accepted item, and compares each
// result transfer field by field with the oldest state still due.
// ----------------------------------------------------------------------------
module fcou_camera_checker
  import fcou_pkg::*;
#(
  parameter int unsigned SINE_TABLE_DEPTH       = 1024,
  parameter int unsigned POSITION_FRACTION_BITS = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // Configuration write port.
  input  logic                cfg_we_i,
  input  logic                cfg_index_i,
  input  logic [SPEED_W-1:0]  cfg_data_i,
  // Item channel.
  input  logic                push,
  input  logic                full,
  input  logic                operation_i,
  input  logic                move_forward_i,
  input  logic                move_back_i,
  input  logic                move_left_i,
  input  logic                move_right_i,
  input  logic signed [15:0]  x_offset_i,
  input  logic signed [15:0]  y_offset_i,
  // Result channel.
  input  logic                empty,
  input  logic                pop,
  input  logic signed [31:0]  position_x_i,
  input  logic signed [31:0]  position_y_i,
  input  logic signed [31:0]  position_z_i,
  input  logic signed [15:0]  front_x_i,
  input  logic signed [15:0]  front_y_i,
  input  logic signed [15:0]  front_z_i,
  input  logic [15:0]         yaw_angle_i,
  input  logic signed [14:0]  pitch_angle_i,
  // Status for the testbench top.
  output int                  mismatches_o,
  output int                  outstanding_o,
  output int                  checked_o
);

  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
  localparam int unsigned     POS_SHIFT   = 30 - POSITION_FRACTION_BITS;
  localparam longint          POS_MAX     = 64'sd2147483647;
  localparam longint          POS_MIN     = -64'sd2147483648;

  // Whole camera state as carried by one result.
  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [15:0] dir_x;
    logic signed [15:0] dir_y;
    logic signed [15:0] dir_z;
    logic [15:0]        yaw;
    logic signed [14:0] pitch;
  } camera_t;

  int                 sine_lut [0:SINE_TABLE_DEPTH];
  camera_t            camera;
  camera_t            camera_states_due [$];
  camera_t            due_state;
  logic [SPEED_W-1:0] speed;
  logic [SENS_W-1:0]  sens;
  int                 mismatch_total;
  int                 checked_total;

  // Quarter-wave sine entry in Q1.14, built from a Q30 Taylor series.
  function automatic int series_sine(int unsigned i);
    longint unsigned x;
    longint unsigned x2;
    longint unsigned term;
    longint          acc;
    int              k;
    x = i;
    x = (HALF_PI_Q30 * x) / SINE_TABLE_DEPTH;
    x2 = (x * x) >> 30;
    term = x;
    acc = x;
    for (k = 1; k <= 12 && term != 0; k++) begin
      term = ((term * x2) >> 30) / ((2 * k) * (2 * k + 1));
      if (k % 2 == 1) begin
        acc = acc - term;
      end else begin
        acc = acc + term;
      end
    end
    if (acc < 0) begin
      acc = 0;
    end
    acc = (acc + 32768) / 65536;
    if (acc > 16384) begin
      acc = 16384;
    end
    return int'(acc);
  endfunction

  // Sine of a 16-bit angle: quadrant from the top two bits, mirrored lookup.
  function automatic longint lut_sine(logic [15:0] angle);
    int unsigned idx;
    longint      v;
    idx = (angle[13:0] * SINE_TABLE_DEPTH + 8192) >> 14;
    if (idx > SINE_TABLE_DEPTH) begin
      idx = SINE_TABLE_DEPTH;
    end
    v = angle[14] ? sine_lut[SINE_TABLE_DEPTH - idx] : sine_lut[idx];
    return angle[15] ? -v : v;
  endfunction

  // Arithmetic right shift with rounding to nearest, ties upward.
  function automatic longint round_half_up(longint v, int unsigned sh);
    return (v + (longint'(1) <<< (sh - 1))) >>> sh;
  endfunction

  // Mouse counts scaled by the Q8.8 sensitivity into angle units.
  function automatic longint mouse_delta(logic signed [15:0] counts,
                                         logic [SENS_W-1:0] gain);
    longint c;
    longint g;
    c = counts;
    g = gain;
    return round_half_up(c * g, 8);
  endfunction

  // Position update that sticks at the ends of the signed 32-bit range.
  function automatic logic signed [31:0] clamp_add(logic signed [31:0] p,
                                                   longint d);
    longint s;
    s = p;
    s = s + d;
    if (s > POS_MAX) begin
      s = POS_MAX;
    end
    if (s < POS_MIN) begin
      s = POS_MIN;
    end
    return s[31:0];
  endfunction

  // Camera state after one item.
  function automatic camera_t advance_camera(camera_t c, logic op, logic fwd,
                                             logic back, logic left,
                                             logic right,
                                             logic signed [15:0] dx,
                                             logic signed [15:0] dy);
    camera_t     n;
    longint      p;
    longint      yaw_sum;
    longint      sy;
    longint      cy;
    longint      sp;
    longint      cp;
    longint      sf;
    longint      ss;
    longint      spd;
    logic [15:0] pa;
    n = c;
    if (op == OP_ROTATE) begin
      // Yaw wraps around the full turn, pitch is clamped.
      yaw_sum = c.yaw;
      yaw_sum = yaw_sum + mouse_delta(dx, sens);
      n.yaw = yaw_sum[15:0];
      p = c.pitch;
      p = p + mouse_delta(dy, sens);
      if (p > PITCH_LIMIT) begin
        p = PITCH_LIMIT;
      end
      if (p < -PITCH_LIMIT) begin
        p = -PITCH_LIMIT;
      end
      n.pitch = p[14:0];
      pa = p[15:0];
      // Front vector is rebuilt even when the angles did not move.
      sy = lut_sine(n.yaw);
      cy = lut_sine(n.yaw + ANGLE_QUARTER);
      sp = lut_sine(pa);
      cp = lut_sine(pa + ANGLE_QUARTER);
      n.dir_x = round_half_up(cy * cp, 14);
      n.dir_y = sp;
      n.dir_z = round_half_up(sy * cp, 14);
    end else begin
      // Opposite flags cancel; right vector is (-sin yaw, 0, cos yaw).
      sf = fwd;
      sf = sf - back;
      ss = right;
      ss = ss - left;
      spd = speed;
      sy = lut_sine(c.yaw);
      cy = lut_sine(c.yaw + ANGLE_QUARTER);
      n.pos_x = clamp_add(c.pos_x, round_half_up((sf * c.dir_x - ss * sy) * spd,
                                                 POS_SHIFT));
      n.pos_y = clamp_add(c.pos_y, round_half_up((sf * c.dir_y) * spd, POS_SHIFT));
      n.pos_z = clamp_add(c.pos_z, round_half_up((sf * c.dir_z + ss * cy) * spd,
                                                 POS_SHIFT));
    end
    return n;
  endfunction

  function automatic void check_field(string field, logic signed [63:0] want,
                                      logic signed [63:0] got);
    if (want !== got) begin
      mismatch_total++;
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
    end
  endfunction

  // Fill the sine table once at the start.
  initial begin
    int i;
    for (i = 0; i <= SINE_TABLE_DEPTH; i++) begin
      sine_lut[i] = series_sine(i);
    end
  end

  // Track configuration, predict on each item transfer, check each result.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      camera.pos_x = '0;
      camera.pos_y = '0;
      camera.pos_z = 32'(longint'(3) <<< POSITION_FRACTION_BITS);
      camera.dir_x = '0;
      camera.dir_y = '0;
      camera.dir_z = -ONE_Q14;
      camera.yaw = YAW_RESET;
      camera.pitch = '0;
      speed = SPEED_RESET;
      sens = SENS_RESET;
      camera_states_due.delete();
      mismatch_total = 0;
      checked_total = 0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_index_i == CFG_MOVE_SPEED) begin
          speed = cfg_data_i[SPEED_W-1:0];
        end else if (cfg_index_i == CFG_TURN_SENS) begin
          sens = cfg_data_i[SENS_W-1:0];
        end
      end
      if (!empty && pop) begin
        if (camera_states_due.size() == 0) begin
          mismatch_total++;
          $display("%0t: result transfer with no camera state due", $time);
        end else begin
          due_state = camera_states_due.pop_front();
          check_field("position_x", due_state.pos_x, position_x_i);
          check_field("position_y", due_state.pos_y, position_y_i);
          check_field("position_z", due_state.pos_z, position_z_i);
          check_field("front_x", due_state.dir_x, front_x_i);
          check_field("front_y", due_state.dir_y, front_y_i);
          check_field("front_z", due_state.dir_z, front_z_i);
          check_field("yaw_angle", {48'd0, due_state.yaw}, {48'd0, yaw_angle_i});
          check_field("pitch_angle", due_state.pitch, pitch_angle_i);
          checked_total++;
        end
      end
      if (push && !full) begin
        camera = advance_camera(camera, operation_i, move_forward_i, move_back_i,
                                move_left_i, move_right_i, x_offset_i, y_offset_i);
        camera_states_due.push_back(camera);
      end
    end
    mismatches_o <= mismatch_total;
    outstanding_o <= camera_states_due.size();
    checked_o <= checked_total;
  end

endmodule

>>> dv/tb_fly_camera_orientation_update.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_fly_camera_orientation_update
// Drives items, register writes and result pops into the fly camera updater.
// A directed opening covers single, opposing and combined direction flags, both operations and the
// angle extremes; random phases follow under several speed and sensitivity
// settings, and a sprint at top speed pushes the position into saturation.
// Checking is done by the checker instance beside the block.
// ----------------------------------------------------------------------------
module tb_fly_camera_orientation_update;
  import fcou_pkg::*;

  // Direction flag groups, ordered forward, back, left, right.
  localparam logic [3:0] GO_NONE    = 4'b0000;
  localparam logic [3:0] GO_FORWARD = 4'b1000;
  localparam logic [3:0] GO_BACK    = 4'b0100;
  localparam logic [3:0] GO_LEFT    = 4'b0010;
  localparam logic [3:0] GO_RIGHT   = 4'b0001;

  logic                clk_i          = 1'b0;
  logic                rst_ni         = 1'b0;
  logic                cfg_we_i       = 1'b0;
  logic                cfg_index_i    = CFG_MOVE_SPEED;
  logic [SPEED_W-1:0]  cfg_data_i     = '0;
  logic                push           = 1'b0;
  logic                operation_i    = OP_TRANSLATE;
  logic                move_forward_i = 1'b0;
  logic                move_back_i    = 1'b0;
  logic                move_left_i    = 1'b0;
  logic                move_right_i   = 1'b0;
  logic signed [15:0]  x_offset_i     = '0;
  logic signed [15:0]  y_offset_i     = '0;
  logic                pop            = 1'b0;
  logic                full;
  logic                empty;
  logic signed [31:0]  position_x_o;
  logic signed [31:0]  position_y_o;
  logic signed [31:0]  position_z_o;
  logic signed [15:0]  front_x_o;
  logic signed [15:0]  front_y_o;
  logic signed [15:0]  front_z_o;
  logic [15:0]         yaw_angle_o;
  logic signed [14:0]  pitch_angle_o;

  int send_idle_pct  = 0;
  int recv_idle_pct  = 0;
  int hold_request   = 0;
  int hold_left      = 0;
  int items_sent     = 0;
  int settings_used  = 0;
  int mismatches;
  int outstanding;
  int checked;

  fly_camera_orientation_update dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .push           (push),
    .full           (full),
    .operation_i    (operation_i),
    .move_forward_i (move_forward_i),
    .move_back_i    (move_back_i),
    .move_left_i    (move_left_i),
    .move_right_i   (move_right_i),
    .x_offset_i     (x_offset_i),
    .y_offset_i     (y_offset_i),
    .empty          (empty),
    .pop            (pop),
    .position_x_o   (position_x_o),
    .position_y_o   (position_y_o),
    .position_z_o   (position_z_o),
    .front_x_o      (front_x_o),
    .front_y_o      (front_y_o),
    .front_z_o      (front_z_o),
    .yaw_angle_o    (yaw_angle_o),
    .pitch_angle_o  (pitch_angle_o)
  );

  fcou_camera_checker checker_i (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .push           (push),
    .full           (full),
    .operation_i    (operation_i),
    .move_forward_i (move_forward_i),
    .move_back_i    (move_back_i),
    .move_left_i    (move_left_i),
    .move_right_i   (move_right_i),
    .x_offset_i     (x_offset_i),
    .y_offset_i     (y_offset_i),
    .empty          (empty),
    .pop            (pop),
    .position_x_i   (position_x_o),
    .position_y_i   (position_y_o),
    .position_z_i   (position_z_o),
    .front_x_i      (front_x_o),
    .front_y_i      (front_y_o),
    .front_z_i      (front_z_o),
    .yaw_angle_i    (yaw_angle_o),
    .pitch_angle_i  (pitch_angle_o),
    .mismatches_o   (mismatches),
    .outstanding_o  (outstanding),
    .checked_o      (checked)
  );

  // 2 ns clock.
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Result side: random pops, or a long hold-off when one is requested.
  always @(posedge clk_i) begin
    if (hold_left == 0 && hold_request != 0) begin
      hold_left = hold_request;
      hold_request = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      pop <= 1'b0;
    end else begin
      pop <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Offer one item, with random idle cycles first, until it transfers.
  task automatic send_item(input logic op, input logic [3:0] dirs,
                           input logic signed [15:0] dx,
                           input logic signed [15:0] dy);
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(posedge clk_i);
    end
    push <= 1'b1;
    operation_i <= op;
    {move_forward_i, move_back_i, move_left_i, move_right_i} <= dirs;
    x_offset_i <= dx;
    y_offset_i <= dy;
    @(posedge clk_i);
    while (full) begin
      @(posedge clk_i);
    end
    items_sent++;
  endtask

  // Mostly small mouse moves and walking, with some full-range jumps.
  task automatic random_item();
    int pick;
    pick = $urandom_range(99);
    if (pick < 50) begin
      send_item(OP_TRANSLATE, 4'($urandom), 16'($urandom), 16'($urandom));
    end else if (pick < 85) begin
      send_item(OP_ROTATE, 4'($urandom), 16'($urandom_range(800) - 400),
                16'($urandom_range(800) - 400));
    end else begin
      send_item(OP_ROTATE, 4'($urandom), 16'($urandom), 16'($urandom));
    end
  endtask

  // Stop offering and wait until every result has been taken.
  task automatic wait_drained();
    push <= 1'b0;
    @(posedge clk_i);
    while (outstanding != 0) begin
      @(posedge clk_i);
    end
  endtask

  // Write both registers back to back; only called on an idle block.
  task automatic program_camera(input logic [SPEED_W-1:0] speed_word,
                                input logic [SPEED_W-1:0] sens_word);
    cfg_we_i <= 1'b1;
    cfg_index_i <= CFG_MOVE_SPEED;
    cfg_data_i <= speed_word;
    @(posedge clk_i);
    cfg_index_i <= CFG_TURN_SENS;
    cfg_data_i <= sens_word;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    settings_used++;
  endtask

  // Stimulus and verdict.
  initial begin
    int phase;
    int n;
    send_idle_pct = 19;
    recv_idle_pct = 81;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed opening with the reset register values.
    send_item(OP_TRANSLATE, GO_NONE, 16'sd0, 16'sd0);
    send_item(OP_TRANSLATE, GO_FORWARD, 16'sd0, 16'sd0);
    send_item(OP_TRANSLATE, GO_BACK, 16'sd0, 16'sd0);
    send_item(OP_TRANSLATE, GO_LEFT, 16'sd0, 16'sd0);
    send_item(OP_TRANSLATE, GO_RIGHT, 16'sd0, 16'sd0);
    send_item(OP_TRANSLATE, GO_FORWARD | GO_BACK, 16'sd0, 16'sd0);
    send_item(OP_TRANSLATE, GO_LEFT | GO_RIGHT, 16'sd0, 16'sd0);
    send_item(OP_TRANSLATE, GO_FORWARD | GO_BACK | GO_LEFT | GO_RIGHT,
              16'sd32767, -16'sd32768);
    send_item(OP_ROTATE, GO_NONE, 16'sd0, 16'sd0);
    send_item(OP_ROTATE, GO_NONE, 16'sd32767, 16'sd32767);
    send_item(OP_ROTATE, GO_FORWARD | GO_BACK | GO_LEFT | GO_RIGHT,
              -16'sd32768, -16'sd32768);
    send_item(OP_ROTATE, GO_NONE, 16'sd1, -16'sd1);
    send_item(OP_ROTATE, GO_NONE, -16'sd1, 16'sd1);
    send_item(OP_TRANSLATE, GO_FORWARD | GO_RIGHT, 16'sd0, 16'sd0);
    send_item(OP_TRANSLATE, GO_BACK | GO_LEFT, 16'sd0, 16'sd0);
    send_item(OP_ROTATE, GO_NONE, 16'sd400, -16'sd250);
    send_item(OP_TRANSLATE, GO_FORWARD, 16'sd0, 16'sd0);
    wait_drained();

    // Random phases, each under its own register setting.
    for (phase = 0; phase < 5; phase++) begin
      if (phase < 2) begin
        send_idle_pct = 19;
        recv_idle_pct = 81;
      end else if (phase < 4) begin
        send_idle_pct = 81;
        recv_idle_pct = 19;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      case (phase)
        0: program_camera(SPEED_RESET, {8'd0, SENS_RESET});
        1: program_camera(24'd0, 24'd0);
        2: program_camera(24'hFFFFFF, 24'h00FFFF);
        3: program_camera(24'($urandom), 24'($urandom));
        default: program_camera(24'($urandom_range(1 << 18)),
                                24'($urandom_range(2000)));
      endcase
      for (n = 0; n < 110; n++) begin
        // Stall the result side for a long stretch so the block backs up.
        if (phase == 4 && n == 20) begin
          hold_request = 300;
        end
        random_item();
      end
      wait_drained();
    end

    // Sprint at top speed: level the pitch exactly, then run both ways
    // far enough to pin the horizontal position at both range limits.
    // The sensitivity word carries junk above bit 15 that must be dropped.
    program_camera(24'hFFFFFF, 24'hA50100);
    send_item(OP_ROTATE, GO_NONE, 16'($urandom), -16'sd32768);
    send_item(OP_ROTATE, GO_NONE, 16'($urandom), 16'sd16201);
    repeat (270) send_item(OP_TRANSLATE, GO_FORWARD | GO_RIGHT, 16'($urandom),
                           16'($urandom));
    repeat (270) send_item(OP_TRANSLATE, GO_BACK | GO_LEFT, 16'($urandom),
                           16'($urandom));
    wait_drained();

    repeat (30) @(posedge clk_i);
    $display("Sent %0d camera updates, checked %0d results over %0d register settings,",
             items_sent, checked, settings_used);
    $display("including idle register values, full-scale values and a saturating sprint.");
    if (mismatches == 0) begin
      $display("[fly_camera_orientation_update] OK");
    end else begin
      $display("[fly_camera_orientation_update] ERROR");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #2000000;
    $display("Timeout with %0d results still due", outstanding);
    $display("[fly_camera_orientation_update] ERROR");
    $finish;
  end

endmodule
